### design/shape_area_heron_core_assert.svh
// assertion macros for the shape area core
// expects clk_i and rst_ni in the scope that uses them
`ifndef SHAPE_AREA_HERON_CORE_ASSERT_SVH
`define SHAPE_AREA_HERON_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define SAH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SAH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sah_pkg.sv
// shared widths, types and constants of the shape area core
// no dependencies
package sah_pkg;

  // payload field widths
  localparam int FieldW = 16;
  localparam int AreaW  = 32;

  // sides are taken in their low SideWidth bits (at most FieldW)
  localparam int SideWidth = 16;

  // derived arithmetic widths
  localparam int SumW  = SideWidth + 2;          // a+b+c
  localparam int DiffW = SideWidth + 1;          // b+c-a etc. when positive
  localparam int P1W   = SumW + DiffW;           // (a+b+c)(b+c-a)
  localparam int P2W   = 2 * DiffW;              // (a+c-b)(a+b-c)
  localparam int P2LoW = P2W / 2;                // low slice for the split multiply
  localparam int P2HiW = P2W - P2LoW;
  localparam int PartW = P1W + P2HiW;            // partial product width
  localparam int RootW = 2 * SideWidth + 2;      // root of the radicand
  localparam int RadW  = 2 * RootW;              // radicand width
  localparam int RemW  = RootW + 2;

  // shape kinds
  localparam logic ModeTriangle  = 1'b0;
  localparam logic ModeRectangle = 1'b1;

  // output of the side check stage
  typedef struct packed {
    logic                 mode;
    logic                 ok;
    logic [SideWidth-1:0] side_a;
    logic [SideWidth-1:0] side_b;
    logic [SumW-1:0]      sum;
    logic [DiffW-1:0]     diff_a;
    logic [DiffW-1:0]     diff_b;
    logic [DiffW-1:0]     diff_c;
  } prep_t;

  // information that rides along with the root computation
  typedef struct packed {
    logic             rect;
    logic             ok;
    logic [AreaW-1:0] rect_area;
  } tag_t;

  // state of one root stage
  typedef struct packed {
    tag_t            tag;
    logic [RemW-1:0] rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0] rad;
  } sq_t;

endpackage

### design/sah_in_if.sv
// input channel of the shape area core: shape kind and three sides
// depends on sah_pkg
interface sah_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [sah_pkg::FieldW-1:0]    side_a;
  logic [sah_pkg::FieldW-1:0]    side_b;
  logic [sah_pkg::FieldW-1:0]    side_c;

  modport source (output valid, mode, side_a, side_b, side_c, input ready);
  modport sink   (input valid, mode, side_a, side_b, side_c, output ready);
endinterface

### design/sah_out_if.sv
// output channel of the shape area core: area and shape flag
// depends on sah_pkg
interface sah_out_if;
  logic                       valid;
  logic                       ready;
  logic [sah_pkg::AreaW-1:0]  area;
  logic                       shape_valid;

  modport source (output valid, area, shape_valid, input ready);
  modport sink   (input valid, area, shape_valid, output ready);
endinterface

### design/shape_area_heron_core.sv
// shape area core: triangle by Heron's formula, rectangle by side product
// pipeline: side check, multiply, square root (one root bit per stage), output register
// throughput one shape per cycle; a held result freezes the whole pipeline
// reset clears every stage valid bit and the output valid bit; payload is not reset
// depends on sah_pkg, sah_in_if, sah_out_if, sah_prep, sah_mul, sah_sqrt_stage
module shape_area_heron_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sah_in_if.sink    in_i,
  sah_out_if.source out_o
);
  import sah_pkg::*;

  `include "shape_area_heron_core_assert.svh"

  logic             en;
  logic             prep_valid;
  prep_t            prep_data;
  logic [RootW:0]   sq_valid;
  sq_t              sq_data [0:RootW];
  sq_t              sq_last;
  logic             out_valid_q;
  logic [AreaW-1:0] area_d, area_q;
  logic             shape_valid_q;

  // pipeline advances unless a finished result is still waiting
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // side check
  sah_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .mode_i   (in_i.mode),
    .side_a_i (in_i.side_a),
    .side_b_i (in_i.side_b),
    .side_c_i (in_i.side_c),
    .valid_o  (prep_valid),
    .data_o   (prep_data)
  );

  // radicand products
  sah_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .data_i  (prep_data),
    .valid_o (sq_valid[0]),
    .data_o  (sq_data[0])
  );

  // square root chain, most significant root bit first
  for (genvar gi = 0; gi < RootW; gi++) begin : g_sqrt
    sah_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[gi]),
      .data_i  (sq_data[gi]),
      .valid_o (sq_valid[gi+1]),
      .data_o  (sq_data[gi+1])
    );
  end

  assign sq_last = sq_data[RootW];

  // area select: rectangle product or root over four
  assign area_d = sq_last.tag.rect ? sq_last.tag.rect_area
                                   : AreaW'(sq_last.root[RootW-1:2]);

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sq_valid[RootW];
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      area_q        <= area_d;
      shape_valid_q <= sq_last.tag.rect || sq_last.tag.ok;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.area        = area_q;
  assign out_o.shape_valid = shape_valid_q;

  // checks
  `SAH_ASSERT_IMP(a_bad_tri_zero, out_valid_q && !shape_valid_q, area_q == '0, "failed triangle with nonzero area")
  `SAH_ASSERT_NEXT(a_in_enters, in_i.valid && en, prep_valid, "transfer did not reach the side check stage")
  `SAH_ASSERT_NEXT(a_stall_holds, !en, $stable(sq_valid), "pipeline moved while stalled")

endmodule

### design/sah_prep.sv
// first pipeline stage: side sums, differences and triangle inequality check
// depends on sah_pkg
module sah_prep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic                         mode_i,
  input  logic [sah_pkg::FieldW-1:0]   side_a_i,
  input  logic [sah_pkg::FieldW-1:0]   side_b_i,
  input  logic [sah_pkg::FieldW-1:0]   side_c_i,
  output logic                         valid_o,
  output sah_pkg::prep_t               data_o
);
  import sah_pkg::*;

  logic [SumW-1:0] a_w, b_w, c_w;
  logic [SumW-1:0] sum_w, dif_a_w, dif_b_w, dif_c_w;
  logic            ok_a, ok_b, ok_c, tri_ok;
  logic            valid_q;
  prep_t           data_d, data_q;

  // sides widened for the sums
  assign a_w = SumW'(side_a_i[SideWidth-1:0]);
  assign b_w = SumW'(side_b_i[SideWidth-1:0]);
  assign c_w = SumW'(side_c_i[SideWidth-1:0]);

  // a negative difference wraps and sets the top bit
  assign sum_w   = a_w + b_w + c_w;
  assign dif_a_w = b_w + c_w - a_w;
  assign dif_b_w = a_w + c_w - b_w;
  assign dif_c_w = a_w + b_w - c_w;

  assign ok_a   = !dif_a_w[SumW-1] && (dif_a_w != '0);
  assign ok_b   = !dif_b_w[SumW-1] && (dif_b_w != '0);
  assign ok_c   = !dif_c_w[SumW-1] && (dif_c_w != '0);
  assign tri_ok = (mode_i == ModeTriangle) && ok_a && ok_b && ok_c;

  // differences forced to zero so a failed triangle gives a zero radicand
  always_comb begin
    data_d.mode   = mode_i;
    data_d.ok     = tri_ok;
    data_d.side_a = side_a_i[SideWidth-1:0];
    data_d.side_b = side_b_i[SideWidth-1:0];
    data_d.sum    = sum_w;
    data_d.diff_a = tri_ok ? dif_a_w[DiffW-1:0] : '0;
    data_d.diff_b = tri_ok ? dif_b_w[DiffW-1:0] : '0;
    data_d.diff_c = tri_ok ? dif_c_w[DiffW-1:0] : '0;
  end

  // stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/sah_mul.sv
// multiply stages: factor products, split radicand product and its sum
// depends on sah_pkg
module sah_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  sah_pkg::prep_t   data_i,
  output logic             valid_o,
  output sah_pkg::sq_t     data_o
);
  import sah_pkg::*;

  logic [2:0]       valid_q;

  // first multiply step
  tag_t             tag1_q;
  logic [P1W-1:0]   p1_q;
  logic [P2W-1:0]   p2_q;

  // second multiply step
  tag_t             tag2_q;
  logic [PartW-1:0] part_lo_q;
  logic [PartW-1:0] part_hi_q;

  // radicand sum
  sq_t              sq_q;
  logic [RadW-1:0]  rad_d;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // factor products and rectangle area
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q             <= P1W'(data_i.sum) * P1W'(data_i.diff_a);
      p2_q             <= P2W'(data_i.diff_b) * P2W'(data_i.diff_c);
      tag1_q.rect      <= (data_i.mode == ModeRectangle);
      tag1_q.ok        <= data_i.ok;
      tag1_q.rect_area <= AreaW'(AreaW'(data_i.side_a) * AreaW'(data_i.side_b));
    end
  end

  // radicand product cut into two partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_lo_q <= PartW'(p1_q) * PartW'(p2_q[P2LoW-1:0]);
      part_hi_q <= PartW'(p1_q) * PartW'(p2_q[P2W-1:P2LoW]);
      tag2_q    <= tag1_q;
    end
  end

  // partial products combined; root search starts from zero
  assign rad_d = RadW'(part_lo_q) + (RadW'(part_hi_q) << P2LoW);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q.tag  <= tag2_q;
      sq_q.rem  <= '0;
      sq_q.root <= '0;
      sq_q.rad  <= rad_d;
    end
  end

  assign valid_o = valid_q[2];
  assign data_o  = sq_q;

endmodule

### design/sah_sqrt_stage.sv
// one stage of the digit-by-digit square root: one root bit per stage
// depends on sah_pkg
module sah_sqrt_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  sah_pkg::sq_t   data_i,
  output logic           valid_o,
  output sah_pkg::sq_t   data_o
);
  import sah_pkg::*;

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;
  logic            take;
  logic            valid_q;
  sq_t             data_d, data_q;

  // bring down the next two radicand bits and try root bit one
  assign rem_sh = {data_i.rem[RootW-1:0], data_i.rad[RadW-1:RadW-2]};
  assign trial  = {data_i.root, 2'b01};
  assign take   = (rem_sh >= trial);

  always_comb begin
    data_d.tag  = data_i.tag;
    data_d.rem  = take ? (rem_sh - trial) : rem_sh;
    data_d.root = {data_i.root[RootW-2:0], take};
    data_d.rad  = {data_i.rad[RadW-3:0], 2'b00};
  end

  // stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
